// ----- design/resf_pkg.sv -----
package resf_pkg;

    localparam int IN_W     = 200;
    localparam int OUT_W    = 336;
    localparam int DIV_LAT  = 33;
    localparam int NUM_VALS = 10;

    // Output value slots.
    localparam int V_ENERGY = 0;
    localparam int V_FX     = 1;
    localparam int V_XX     = 4;
    localparam int V_XY     = 5;
    localparam int V_XZ     = 6;
    localparam int V_YY     = 7;
    localparam int V_YZ     = 8;
    localparam int V_ZZ     = 9;

    localparam logic [2:0] ADDR_EXACT = 3'd0;

    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] v;
        logic               ov;
    } sat_t;

    typedef logic [NUM_VALS-1:0][31:0] vals_t;

    typedef struct packed {
        logic [30:0]        ks;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic signed [31:0] d;
        logic [30:0]        l;
        logic               l0z;
        logic               cneg;
        logic [9:0]         idx;
        logic               ov;
    } carry_t;

    // Saturate a sign and magnitude to a signed 32-bit value.
    function automatic sat_t sat_mag(input logic [63:0] m, input logic neg);
        sat_t r;
        if (neg)
        begin
            if (m > 64'h0000_0000_8000_0000)
            begin
                r.v  = INT_MIN;
                r.ov = 1'b1;
            end
            else
            begin
                r.v  = 32'(~m + 64'd1);
                r.ov = 1'b0;
            end
        end
        else
        begin
            if (m > 64'h0000_0000_7FFF_FFFF)
            begin
                r.v  = INT_MAX;
                r.ov = 1'b1;
            end
            else
            begin
                r.v  = m[31:0];
                r.ov = 1'b0;
            end
        end
        return r;
    endfunction

    // Round to nearest with ties away from zero, then saturate.
    function automatic sat_t sat_shift(input logic [63:0] p, input int unsigned sh);
        logic [63:0] m;
        logic [63:0] r;
        m = p[63] ? (~p + 64'd1) : p;
        r = (m + (64'd1 << (sh - 1))) >> sh;
        return sat_mag(r, p[63]);
    endfunction

    function automatic sat_t div_sat(input logic [31:0] q, input logic ovq, input logic neg);
        return sat_mag(ovq ? 64'h0000_0001_0000_0000 : {32'b0, q}, neg);
    endfunction

    function automatic sat_t sat_add(input logic signed [31:0] a, input logic signed [31:0] b);
        logic [32:0] s;
        sat_t r;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
        begin
            r.v  = s[32] ? INT_MIN : INT_MAX;
            r.ov = 1'b1;
        end
        else
        begin
            r.v  = s[31:0];
            r.ov = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- design/rod_edge_stretch_force_core.sv -----
// Channel   Dir  Beat contents (low bits first)
// s_axis    in   edge_length, rest_length, stiffness, tan_x, tan_y, tan_z, edge_index
// m_axis    out  energy, force_x..z, jac_xx, xy, xz, yy, yz, zz, overflow, edge_tag
// apb       in   register 0 at byte address 0: exact_jacobian
//
// One beat is accepted per cycle while s_axis_tready is high. The pipeline depth
// is set by two chained 33-stage radix-2 divider levels (strain and stiffness per
// length by rest length, then the identity term by length). Reset clears all
// valid bits and exact_jacobian; the pipeline is empty. A two-entry output buffer
// absorbs a stall; the whole pipeline holds while its second entry is full, so
// s_axis_tready comes from a register only.
module rod_edge_stretch_force_core
    import resf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // edge_length[30:0], rest_length[61:31],
                                              // stiffness[92:62], tan_x[124:93],
                                              // tan_y[156:125], tan_z[188:157],
                                              // edge_index[198:189], zero pad
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // energy, force_x, force_y, force_z,
                                              // jac_xx, jac_xy, jac_xz, jac_yy, jac_yz,
                                              // jac_zz (32 bits each), overflow[320],
                                              // edge_tag[330:321], zero pad
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int NW  = 32 + FRAC_BITS;
    localparam int DL2 = DIV_LAT - 2;
    localparam int CW  = $bits(carry_t);

    logic en;
    logic exact_reg;

    // Configuration.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_EXACT) ? {31'b0, exact_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exact_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_EXACT))
        begin
            exact_reg <= pwdata[0];
        end
    end

    // Stage A: input register.
    logic              va_reg;
    logic [30:0]       l_a_reg;
    logic [30:0]       l0_a_reg;
    logic [30:0]       ks_a_reg;
    logic signed [31:0] tx_a_reg;
    logic signed [31:0] ty_a_reg;
    logic signed [31:0] tz_a_reg;
    logic [9:0]        idx_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_a_reg   <= s_axis_tdata[30:0];
            l0_a_reg  <= s_axis_tdata[61:31];
            ks_a_reg  <= s_axis_tdata[92:62];
            tx_a_reg  <= s_axis_tdata[124:93];
            ty_a_reg  <= s_axis_tdata[156:125];
            tz_a_reg  <= s_axis_tdata[188:157];
            idx_a_reg <= s_axis_tdata[198:189];
        end
    end

    logic signed [31:0] d_a;
    logic [31:0]        dmag_a;
    logic [NW-1:0]      num_s;
    logic [NW-1:0]      num_k;
    carry_t             carry_a;

    always_comb
    begin
        d_a    = $signed({1'b0, l_a_reg}) - $signed({1'b0, l0_a_reg});
        dmag_a = d_a[31] ? (~d_a + 32'd1) : d_a;
        num_s  = (NW'(dmag_a) << FRAC_BITS) + NW'(l0_a_reg >> 1);
        num_k  = (NW'(ks_a_reg) << FRAC_BITS) + NW'(l0_a_reg >> 1);
        carry_a.ks   = ks_a_reg;
        carry_a.tx   = tx_a_reg;
        carry_a.ty   = ty_a_reg;
        carry_a.tz   = tz_a_reg;
        carry_a.d    = d_a;
        carry_a.l    = l_a_reg;
        carry_a.l0z  = (l0_a_reg == 31'd0);
        carry_a.cneg = 1'b0;
        carry_a.idx  = idx_a_reg;
        carry_a.ov   = 1'b0;
    end

    logic [31:0] qs;
    logic [31:0] qk;
    logic        ovs;
    logic        ovk;
    logic        v1;
    logic [CW-1:0] carry1_bits;
    carry_t      carry1;

    resf_div #(.NW(NW)) u_div_strain (
        .clk (clk), .en (en), .num (num_s), .den (l0_a_reg), .q (qs), .ovq (ovs)
    );

    resf_div #(.NW(NW)) u_div_kstiff (
        .clk (clk), .en (en), .num (num_k), .den (l0_a_reg), .q (qk), .ovq (ovk)
    );

    resf_delay #(.W(CW), .N(DIV_LAT)) u_dly_div1 (
        .clk (clk), .rst_n (rst_n), .en (en), .vin (va_reg), .din (carry_a),
        .vout (v1), .dout (carry1_bits)
    );

    assign carry1 = carry_t'(carry1_bits);

    // Stage B: saturate the quotients.
    logic               vb_reg;
    logic signed [31:0] s_b_reg;
    logic signed [31:0] k_b_reg;
    carry_t             carry_b_reg;
    carry_t             carry_b_next;
    sat_t               s_sat;
    sat_t               k_sat;

    always_comb
    begin
        s_sat = div_sat(qs, ovs, carry1.d[31]);
        k_sat = div_sat(qk, ovk, 1'b0);
        carry_b_next    = carry1;
        carry_b_next.ov = s_sat.ov | k_sat.ov;
    end

    // Stage C: products. Stage D: round and saturate them.
    logic               vc_reg;
    logic signed [63:0] cprod_c_reg;
    logic signed [63:0] pprod_c_reg [0:5];
    logic signed [31:0] k_c_reg;
    carry_t             carry_c_reg;

    logic               vd_reg;
    logic signed [31:0] c_d_reg;
    logic signed [31:0] p_d_reg [0:5];
    logic signed [31:0] k_d_reg;
    carry_t             carry_d_reg;

    logic signed [31:0] ks_b_s;
    sat_t               c_sat;
    sat_t               p_sat [0:5];
    logic               ov_d;
    carry_t             carry_d_next;

    always_comb
    begin
        ks_b_s = $signed({1'b0, carry_b_reg.ks});
        c_sat  = sat_shift(cprod_c_reg, FRAC_BITS);
        ov_d   = carry_c_reg.ov | c_sat.ov;
        for (int i = 0; i < 6; i++)
        begin
            p_sat[i] = sat_shift(pprod_c_reg[i], FRAC_BITS);
            ov_d     = ov_d | p_sat[i].ov;
        end
        carry_d_next      = carry_c_reg;
        carry_d_next.ov   = ov_d;
        carry_d_next.cneg = c_sat.v[31];
    end

    // Stage E: energy, force and outer-product products. Stage F: rounding.
    logic               ve_reg;
    logic signed [63:0] prod_e_reg [0:NUM_VALS-1];
    carry_t             carry_e_reg;

    logic               vf_reg;
    vals_t              vals_f_reg;
    carry_t             carry_f_reg;

    sat_t               val_sat [0:NUM_VALS-1];
    logic               ov_f;
    carry_t             carry_f_next;

    always_comb
    begin
        ov_f = carry_e_reg.ov;
        for (int i = 0; i < NUM_VALS; i++)
        begin
            val_sat[i] = sat_shift(prod_e_reg[i],
                                   (i == V_ENERGY) ? FRAC_BITS + 1 : FRAC_BITS);
            ov_f = ov_f | val_sat[i].ov;
        end
        carry_f_next    = carry_e_reg;
        carry_f_next.ov = ov_f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            vb_reg <= v1;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_b_reg        <= s_sat.v;
            k_b_reg        <= k_sat.v;
            carry_b_reg    <= carry_b_next;

            cprod_c_reg    <= ks_b_s * s_b_reg;
            pprod_c_reg[0] <= carry_b_reg.tx * carry_b_reg.tx;
            pprod_c_reg[1] <= carry_b_reg.tx * carry_b_reg.ty;
            pprod_c_reg[2] <= carry_b_reg.tx * carry_b_reg.tz;
            pprod_c_reg[3] <= carry_b_reg.ty * carry_b_reg.ty;
            pprod_c_reg[4] <= carry_b_reg.ty * carry_b_reg.tz;
            pprod_c_reg[5] <= carry_b_reg.tz * carry_b_reg.tz;
            k_c_reg        <= k_b_reg;
            carry_c_reg    <= carry_b_reg;

            c_d_reg          <= c_sat.v;
            for (int i = 0; i < 6; i++)
            begin
                p_d_reg[i] <= p_sat[i].v;
            end
            k_d_reg          <= k_c_reg;
            carry_d_reg      <= carry_d_next;

            prod_e_reg[V_ENERGY] <= c_d_reg * carry_d_reg.d;
            prod_e_reg[V_FX]     <= c_d_reg * carry_d_reg.tx;
            prod_e_reg[V_FX + 1] <= c_d_reg * carry_d_reg.ty;
            prod_e_reg[V_FX + 2] <= c_d_reg * carry_d_reg.tz;
            for (int i = 0; i < 6; i++)
            begin
                prod_e_reg[V_XX + i] <= k_d_reg * p_d_reg[i];
            end
            carry_e_reg <= carry_d_reg;

            for (int i = 0; i < NUM_VALS; i++)
            begin
                vals_f_reg[i] <= val_sat[i].v;
            end
            carry_f_reg    <= carry_f_next;
        end
    end

    // Identity term: c divided by the current length, started from stage D.
    logic [31:0]   cmag_d;
    logic [NW-1:0] num_g;
    logic [31:0]   qg;
    logic          ovg;

    always_comb
    begin
        cmag_d = c_d_reg[31] ? (~c_d_reg + 32'd1) : c_d_reg;
        num_g  = (NW'(cmag_d) << FRAC_BITS) + NW'(carry_d_reg.l >> 1);
    end

    resf_div #(.NW(NW)) u_div_ident (
        .clk (clk), .en (en), .num (num_g), .den (carry_d_reg.l), .q (qg), .ovq (ovg)
    );

    logic                  v2;
    logic [$bits(vals_t)+CW-1:0] dly2_bits;
    vals_t                 vals2;
    carry_t                carry2;

    resf_delay #(.W($bits(vals_t) + CW), .N(DL2)) u_dly_div2 (
        .clk (clk), .rst_n (rst_n), .en (en), .vin (vf_reg),
        .din ({vals_f_reg, carry_f_reg}), .vout (v2), .dout (dly2_bits)
    );

    assign vals2  = vals_t'(dly2_bits[$bits(vals_t)+CW-1:CW]);
    assign carry2 = carry_t'(dly2_bits[CW-1:0]);

    // Stage G: saturate the identity term.
    logic               vg_reg;
    logic signed [31:0] g_g_reg;
    vals_t              vals_g_reg;
    carry_t             carry_g_reg;
    sat_t               g_sat;
    logic               use_g2;
    carry_t             carry_g_next;

    always_comb
    begin
        g_sat  = div_sat(qg, ovg, carry2.cneg);
        use_g2 = exact_reg && (carry2.l != 31'd0);
        carry_g_next    = carry2;
        carry_g_next.ov = carry2.ov | (use_g2 & g_sat.ov);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vg_reg <= 1'b0;
        end
        else if (en)
        begin
            vg_reg <= v2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_g_reg        <= g_sat.v;
            vals_g_reg     <= vals2;
            carry_g_reg    <= carry_g_next;
        end
    end

    // Final stage: diagonal add, special cases and packing.
    logic               lzero_g;
    logic               use_g;
    sat_t               dsum [0:2];
    vals_t              vals_h;
    logic               ov_h;
    logic [OUT_W-1:0]   res_next;

    always_comb
    begin
        lzero_g = (carry_g_reg.l == 31'd0);
        use_g   = exact_reg && !lzero_g;
        vals_h  = vals_g_reg;
        ov_h    = carry_g_reg.ov | lzero_g;
        dsum[0] = sat_add(vals_g_reg[V_XX], g_g_reg);
        dsum[1] = sat_add(vals_g_reg[V_YY], g_g_reg);
        dsum[2] = sat_add(vals_g_reg[V_ZZ], g_g_reg);
        if (use_g)
        begin
            vals_h[V_XX] = dsum[0].v;
            vals_h[V_YY] = dsum[1].v;
            vals_h[V_ZZ] = dsum[2].v;
            ov_h = ov_h | dsum[0].ov | dsum[1].ov | dsum[2].ov;
        end
        if (carry_g_reg.l0z)
        begin
            vals_h = '0;
            ov_h   = 1'b1;
        end
        res_next = '0;
        for (int i = 0; i < NUM_VALS; i++)
        begin
            res_next[32*i +: 32] = vals_h[i];
        end
        res_next[320]     = ov_h;
        res_next[330:321] = carry_g_reg.idx;
    end

    // Output register with one skid entry behind it.
    logic             o_valid_reg;
    logic [OUT_W-1:0] o_data_reg;
    logic             skid_valid_reg;
    logic [OUT_W-1:0] skid_data_reg;
    logic             arrive;
    logic             take;

    assign en     = !skid_valid_reg;
    assign arrive = en && vg_reg;
    assign take   = o_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take || !o_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                o_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                o_valid_reg <= arrive;
            end
        end
        else if (arrive)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take || !o_valid_reg)
        begin
            o_data_reg <= skid_valid_reg ? skid_data_reg : res_next;
        end
        else if (arrive)
        begin
            skid_data_reg <= res_next;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = o_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> o_valid_reg)
        else $error("skid entry holds a beat while the output register is empty");

    a_hold_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && m_axis_tready |=> !skid_valid_reg)
        else $error("skid entry not drained after an output beat");

endmodule

// ----- design/resf_div.sv -----
module resf_div #(
    parameter int NW = 48
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [30:0]   den,
    output logic [31:0]   q,
    output logic          ovq
);

    logic [30:0] rem_reg [0:32];
    logic [31:0] lo_reg  [0:32];
    logic [31:0] q_reg   [0:32];
    logic [30:0] den_reg [0:32];
    logic        ov_reg  [0:32];

    // The upper bits of the numerator decide whether the quotient fits 32 bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= 31'(num[NW-1:32]);
            ov_reg[0]  <= 31'(num[NW-1:32]) >= den;
            lo_reg[0]  <= num[31:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den;
        end
    end

    for (genvar j = 1; j <= 32; j++)
    begin : g_step
        logic [31:0] trial;
        logic [31:0] diff;
        logic        ge;

        always_comb
        begin
            trial = {rem_reg[j-1], lo_reg[j-1][31]};
            diff  = trial - {1'b0, den_reg[j-1]};
            ge    = trial >= {1'b0, den_reg[j-1]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? diff[30:0] : trial[30:0];
                lo_reg[j]  <= {lo_reg[j-1][30:0], 1'b0};
                q_reg[j]   <= {q_reg[j-1][30:0], ge};
                den_reg[j] <= den_reg[j-1];
                ov_reg[j]  <= ov_reg[j-1];
            end
        end
    end

    assign q   = q_reg[32];
    assign ovq = ov_reg[32];

endmodule

// ----- design/resf_delay.sv -----
module resf_delay #(
    parameter int W = 8,
    parameter int N = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         vin,
    input  logic [W-1:0] din,
    output logic         vout,
    output logic [W-1:0] dout
);

    logic         v_reg [0:N-1];
    logic [W-1:0] d_reg [0:N-1];

    for (genvar i = 0; i < N; i++)
    begin : g_tap
        logic         v_prev;
        logic [W-1:0] d_prev;

        if (i == 0)
        begin : g_first
            assign v_prev = vin;
            assign d_prev = din;
        end
        else
        begin : g_rest
            assign v_prev = v_reg[i-1];
            assign d_prev = d_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[i] <= d_prev;
            end
        end
    end

    assign vout = v_reg[N-1];
    assign dout = d_reg[N-1];

endmodule
